>>> sv/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared codes, types and helpers of the prefix code tree decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // Request codes of an input item; also used as queued operation codes.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_BIT  = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_OVERRUN = 2'd2;

  // Width of the code_bits field and its value as a length.
  localparam int         CODE_W     = 12;
  localparam logic [3:0] CODE_W_LEN = 4'd12;

  // Queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Classified operation as it waits in the queue (node address travels apart).
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] sym;
    logic       stream_bit;
  } cmd_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_status_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

>>> sv/pctd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_in_if / pctd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pctd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  code_symbol;
  logic [11:0] code_bits;
  logic [3:0]  code_len;
  logic        stream_bit;

  modport source (output valid, req_type, code_symbol, code_bits, code_len, stream_bit,
                  input ready);
  modport sink (input valid, req_type, code_symbol, code_bits, code_len, stream_bit,
                output ready);
endinterface

interface pctd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  symbol;
  logic [31:0] symbols_decoded;
  logic [31:0] bits_consumed;

  modport source (output valid, result_kind, symbol, symbols_decoded, bits_consumed,
                  input ready);
  modport sink (input valid, result_kind, symbol, symbols_decoded, bits_consumed,
                output ready);
endinterface

>>> sv/pctd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_front
// Accepts input items, drops those with no effect, turns a load's code into
// a tree node address and queues the rest for the back end.
// ----------------------------------------------------------------------------
module pctd_front #(
  parameter int MAX_CODE_LEN = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  pctd_in_if.sink                 in_ch,
  input  pctd_pkg::bk_status_t    st,
  output logic                    head_valid,
  output pctd_pkg::cmd_t          head_cmd,
  output logic [MAX_CODE_LEN:0]   head_addr
);

  localparam int AW = MAX_CODE_LEN + 1;
  localparam int NW = (AW > pctd_pkg::CODE_W + 1) ? AW : pctd_pkg::CODE_W + 1;
  localparam logic [4:0] LEN_MAX = 5'(MAX_CODE_LEN);

  pctd_pkg::cmd_t                  q_cmd_r  [pctd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]                   q_addr_r [pctd_pkg::QUEUE_DEPTH];
  logic [pctd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [pctd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [pctd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  logic          full;
  logic          accept;
  logic          len_ok;
  logic          keep;
  logic [NW-1:0] code_ext;
  logic [NW-1:0] node_w;
  pctd_pkg::cmd_t new_cmd;

  assign full         = (cnt_r == pctd_pkg::QCNT_W'(pctd_pkg::QUEUE_DEPTH));
  assign in_ch.ready  = !full && !st.clearing;
  assign accept       = in_ch.valid && in_ch.ready;

  assign len_ok = (in_ch.code_len != 4'd0) && ({1'b0, in_ch.code_len} <= LEN_MAX)
                  && (in_ch.code_len <= pctd_pkg::CODE_W_LEN);

  // Loads with a bad length and unused request codes leave no trace.
  assign keep = accept && ((in_ch.req_type == pctd_pkg::REQ_BIT)
                        || (in_ch.req_type == pctd_pkg::REQ_END)
                        || ((in_ch.req_type == pctd_pkg::REQ_LOAD) && len_ok));

  // The node of a code is a leading one above its code_len low bits.
  assign code_ext = NW'(in_ch.code_bits);
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      node_w[i] = (i == int'(in_ch.code_len)) ||
                  ((i < int'(in_ch.code_len)) && code_ext[i]);
    end
  end

  always_comb begin
    new_cmd.op         = in_ch.req_type;
    new_cmd.sym        = in_ch.code_symbol;
    new_cmd.stream_bit = in_ch.stream_bit;
  end

  always_comb begin
    wr_ptr_nxt = keep ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = st.pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + pctd_pkg::QCNT_W'(keep) - pctd_pkg::QCNT_W'(st.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_cmd_r[wr_ptr_r]  <= new_cmd;
      q_addr_r[wr_ptr_r] <= node_w[AW-1:0];
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_cmd_r[rd_ptr_r];
  assign head_addr  = q_addr_r[rd_ptr_r];

endmodule

>>> sv/pctd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_back
// Carries out queued operations: owns the node store, the tree walk, the
// counts and the result register. Sweeps the store to zero after reset.
// ----------------------------------------------------------------------------
module pctd_back #(
  parameter int MAX_CODE_LEN = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  pctd_pkg::cmd_t          head_cmd,
  input  logic [MAX_CODE_LEN:0]   head_addr,
  output pctd_pkg::bk_status_t    st,
  pctd_out_if.source              out_ch
);

  localparam int AW    = MAX_CODE_LEN + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [AW-1:0] ROOT = AW'(1);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;

  logic          state_r, state_nxt;
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [AW-1:0] pend_r, pend_nxt;
  logic [31:0]   syms_r, syms_nxt;
  logic [31:0]   bits_r, bits_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_sym_r, out_sym_nxt;
  logic [31:0]   out_syms_r, out_syms_nxt;
  logic [31:0]   out_bits_r, out_bits_nxt;

  logic          wr_en, rd_en, pop, emit, out_free;
  logic [AW-1:0] wr_addr, rd_addr, next_node;
  logic [7:0]    wr_data;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign next_node = {walk_r[AW-2:0], head_cmd.stream_bit};

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = head_addr;
    wr_data      = head_cmd.sym;
    rd_en        = 1'b0;
    rd_addr      = next_node;
    pop          = 1'b0;
    emit         = 1'b0;
    state_nxt    = state_r;
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    walk_nxt     = walk_r;
    pend_nxt     = pend_r;
    syms_nxt     = syms_r;
    bits_nxt     = bits_r;
    out_kind_nxt = out_kind_r;
    out_sym_nxt  = out_sym_r;
    out_syms_nxt = out_syms_r;
    out_bits_nxt = out_bits_r;

    if (clearing_r) begin
      wr_en        = 1'b1;
      wr_addr      = clr_addr_r;
      wr_data      = 8'd0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clearing_nxt = 1'b0;
      end
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (head_valid) begin
            priority if (head_cmd.op == pctd_pkg::REQ_LOAD) begin
              wr_en = 1'b1;
              pop   = 1'b1;
            end else if (head_cmd.op == pctd_pkg::REQ_END) begin
              if (out_free) begin
                emit         = 1'b1;
                out_kind_nxt = pctd_pkg::KIND_END;
                out_sym_nxt  = 8'd0;
                out_syms_nxt = syms_r;
                out_bits_nxt = bits_r;
                syms_nxt     = '0;
                bits_nxt     = '0;
                walk_nxt     = ROOT;
                pop          = 1'b1;
              end
            end else begin
              // Stream bit. A walk already at the deepest level overruns.
              if (walk_r[AW-1]) begin
                if (out_free) begin
                  emit         = 1'b1;
                  bits_nxt     = pctd_pkg::sat_inc(bits_r);
                  out_kind_nxt = pctd_pkg::KIND_OVERRUN;
                  out_sym_nxt  = 8'd0;
                  out_syms_nxt = syms_r;
                  out_bits_nxt = pctd_pkg::sat_inc(bits_r);
                  walk_nxt     = ROOT;
                  pop          = 1'b1;
                end
              end else begin
                rd_en     = 1'b1;
                pend_nxt  = next_node;
                bits_nxt  = pctd_pkg::sat_inc(bits_r);
                pop       = 1'b1;
                state_nxt = ST_LOOK;
              end
            end
          end
        end
        ST_LOOK: begin
          if (rd_data_r != 8'd0) begin
            if (out_free) begin
              emit         = 1'b1;
              syms_nxt     = pctd_pkg::sat_inc(syms_r);
              out_kind_nxt = pctd_pkg::KIND_SYMBOL;
              out_sym_nxt  = rd_data_r;
              out_syms_nxt = pctd_pkg::sat_inc(syms_r);
              out_bits_nxt = bits_r;
              walk_nxt     = ROOT;
              state_nxt    = ST_RUN;
            end
          end else begin
            walk_nxt  = pend_r;
            state_nxt = ST_RUN;
          end
        end
        default: state_nxt = ST_RUN;
      endcase
    end

    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      walk_r      <= ROOT;
      syms_r      <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      walk_r      <= walk_nxt;
      syms_r      <= syms_nxt;
      bits_r      <= bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_sym_r  <= out_sym_nxt;
    out_syms_r <= out_syms_nxt;
    out_bits_r <= out_bits_nxt;
  end

  // Node store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign st.clearing = clearing_r;
  assign st.pop      = pop;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_kind_r;
  assign out_ch.symbol          = out_sym_r;
  assign out_ch.symbols_decoded = out_syms_r;
  assign out_ch.bits_consumed   = out_bits_r;

endmodule

>>> sv/prefix_code_tree_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_unit
// Prefix code decoder over a heap-ordered code tree held in a node store.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load, stream-bit and end items; out_ch carries decoded
//   symbols, end-of-stream summaries and overrun errors. Each channel moves
//   one item per transfer when valid and ready are both high.
//   A four-entry queue sits behind the input, so items are taken on
//   consecutive cycles until it fills; loads with a bad length and unused
//   request codes are taken and dropped there.
//   A load or end item is carried out in the run state alone. A stream bit
//   also passes the look state (unless it overruns), since the walk must
//   see the node read from the store before the next bit can step. With the
//   queue empty, an end summary or an overrun passes the queue and the output
//   register before it shows on out_ch; a decoded symbol also the node read.
//   After reset all 2^(MAX_CODE_LEN+1) node store entries (8192 by default)
//   are swept to zero, one entry per cycle; in_ch.ready stays low then.
//   Counts and the walk return to zero and the root at reset.
//   When out_ch stalls, the result waits in the output register and the
//   execution stage holds any item that would give another result; the queue
//   keeps taking items until full.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_unit #(
  parameter int MAX_CODE_LEN = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  pctd_in_if.sink     in_ch,
  pctd_out_if.source  out_ch
);

  pctd_pkg::bk_status_t    st;
  pctd_pkg::cmd_t          head_cmd;
  logic                    head_valid;
  logic [MAX_CODE_LEN:0]   head_addr;

  pctd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .st         (st),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_addr  (head_addr)
  );

  pctd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_addr  (head_addr),
    .st         (st),
    .out_ch     (out_ch)
  );

  // No input transfer while the store is being swept.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    st.clearing |-> !in_ch.ready)
    else $error("input taken during store clearing");

  // The back end only takes queued work when there is some and it is not sweeping.
  a_pop_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    st.pop |-> (head_valid && !st.clearing))
    else $error("queue popped while empty or clearing");

  // A decoded symbol is never the empty marker.
  a_symbol_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == pctd_pkg::KIND_SYMBOL) |-> out_ch.symbol != 8'd0)
    else $error("empty node reported as symbol");

  // Summaries and errors carry a zero symbol.
  a_other_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind != pctd_pkg::KIND_SYMBOL) |-> out_ch.symbol == 8'd0)
    else $error("non-symbol result carries a symbol");

endmodule

>>> test/prefix_code_tree_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_unit_tb
// Self-checking bench for the prefix code tree decoder. A short table of
// directed items covers the empty tree, ignored loads, an overrun and node
// clearing. It is followed by random code tables, each loaded and then walked
// by streams of mostly valid codewords. Every result is checked against a
// behavioral decoder kept in the bench. Both channels stall at random.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_unit_tb;

  localparam int          MAX_LEN      = 12;
  localparam int          NODE_COUNT   = 1 << (MAX_LEN + 1);
  localparam logic [12:0] DEEPEST_NODE = 13'(1 << MAX_LEN);
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          ITEM_TARGET  = 950;
  localparam int          DIRECTED_ROWS = 13;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          TIMEOUT_NS   = 1_000_000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  code_symbol;
    logic [11:0] code_bits;
    logic [3:0]  code_len;
    logic        stream_bit;
  } code_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  symbol;
    logic [31:0] sym_count;
    logic [31:0] bit_count;
  } decode_result_t;

  typedef struct packed {
    bit             known;
    decode_result_t res;
  } pinned_result_t;

  typedef struct {
    code_item_t     item;
    int unsigned    reps;
    bit             known;
    decode_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pctd_in_if  in_ch ();
  pctd_out_if out_ch ();

  prefix_code_tree_decoder_unit #(
    .MAX_CODE_LEN(MAX_LEN)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Behavioral decoder state.
  logic [7:0]  tree_nodes [NODE_COUNT];
  logic [12:0] walk_node;
  logic [31:0] sym_total;
  logic [31:0] bit_total;

  decode_result_t expected_results[$];
  pinned_result_t result_pins[$];

  int unsigned mismatch_count = 0;
  int unsigned seen_symbols = 0;
  int unsigned seen_ends = 0;
  int unsigned seen_overruns = 0;
  int unsigned work_items = 0;
  int unsigned hold_requests = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  // Codes of the current table and of the entries still loaded from the last one.
  int unsigned leaf_code[$];
  int unsigned leaf_len[$];
  int unsigned live[$];
  int unsigned old_code[$];
  int unsigned old_len[$];

  initial begin
    foreach (tree_nodes[k]) tree_nodes[k] = 8'd0;
    walk_node = 13'd1;
    sym_total = '0;
    bit_total = '0;
  end

  task automatic decode_step(input code_item_t it, output bit produced,
                             output decode_result_t res);
    logic [12:0] node;
    logic [12:0] len_mask;
    produced = 1'b0;
    res = '0;
    case (it.req_type)
      pctd_pkg::REQ_LOAD: begin
        if (it.code_len != 4'd0 && it.code_len <= MAX_LEN &&
            it.code_len <= pctd_pkg::CODE_W_LEN) begin
          len_mask = (13'd1 << it.code_len) - 13'd1;
          node = (13'd1 << it.code_len) | ({1'b0, it.code_bits} & len_mask);
          tree_nodes[node] = it.code_symbol;
        end
      end
      pctd_pkg::REQ_BIT: begin
        if (bit_total != '1) bit_total = bit_total + 32'd1;
        produced = 1'b1;
        if (walk_node >= DEEPEST_NODE || walk_node == 13'd0) begin
          walk_node = 13'd1;
          res.kind = pctd_pkg::KIND_OVERRUN;
        end else begin
          node = {walk_node[11:0], it.stream_bit};
          if (tree_nodes[node] != 8'd0) begin
            if (sym_total != '1) sym_total = sym_total + 32'd1;
            walk_node = 13'd1;
            res.kind = pctd_pkg::KIND_SYMBOL;
            res.symbol = tree_nodes[node];
          end else begin
            walk_node = node;
            produced = 1'b0;
          end
        end
        res.sym_count = sym_total;
        res.bit_count = bit_total;
      end
      pctd_pkg::REQ_END: begin
        produced = 1'b1;
        res.kind = pctd_pkg::KIND_END;
        res.sym_count = sym_total;
        res.bit_count = bit_total;
        sym_total = '0;
        bit_total = '0;
        walk_node = 13'd1;
      end
      default: ;
    endcase
  endtask

  // Checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin : transfer_monitor
    code_item_t     taken;
    decode_result_t seen;
    decode_result_t want;
    decode_result_t predicted;
    pinned_result_t pin;
    bit             produced;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.kind = out_ch.result_kind;
        seen.symbol = out_ch.symbol;
        seen.sym_count = out_ch.symbols_decoded;
        seen.bit_count = out_ch.bits_consumed;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: kind %0d symbol %0d symbols %0d bits %0d",
                     seen.kind, seen.symbol, seen.sym_count, seen.bit_count);
        end else begin
          want = expected_results.pop_front();
          if (seen.kind !== want.kind || seen.symbol !== want.symbol ||
              seen.sym_count !== want.sym_count || seen.bit_count !== want.bit_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch at %0t: expected kind %0d symbol %0d symbols %0d bits %0d",
                       $realtime, want.kind, want.symbol, want.sym_count, want.bit_count);
              $display("  got kind %0d symbol %0d symbols %0d bits %0d",
                       seen.kind, seen.symbol, seen.sym_count, seen.bit_count);
            end
          end
          case (seen.kind)
            pctd_pkg::KIND_SYMBOL: seen_symbols++;
            pctd_pkg::KIND_END:    seen_ends++;
            default:               seen_overruns++;
          endcase
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.req_type = in_ch.req_type;
        taken.code_symbol = in_ch.code_symbol;
        taken.code_bits = in_ch.code_bits;
        taken.code_len = in_ch.code_len;
        taken.stream_bit = in_ch.stream_bit;
        decode_step(taken, produced, predicted);
        if (result_pins.size() != 0) pin = result_pins.pop_front();
        else pin = '0;
        if (pin.known) expected_results.push_back(pin.res);
        else if (produced) expected_results.push_back(predicted);
      end
    end
  end

  // Result side: random stalls, a steady stretch, and one long hold-off on request.
  initial begin : result_sink
    int unsigned holds_done;
    int unsigned held;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (sink_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  function automatic code_item_t rand_item(input logic [1:0] req);
    code_item_t it;
    it.req_type = req;
    it.code_symbol = 8'($urandom);
    it.code_bits = 12'($urandom);
    it.code_len = 4'($urandom);
    it.stream_bit = 1'($urandom);
    return it;
  endfunction

  function automatic directed_row_t mk_row(input logic [1:0] req, input logic [7:0] sym,
                                           input logic [11:0] bits, input logic [3:0] len,
                                           input logic sbit, input int unsigned reps,
                                           input bit known, input logic [1:0] kind,
                                           input logic [7:0] rsym, input logic [31:0] sc,
                                           input logic [31:0] bc);
    directed_row_t row;
    row.item = '{req_type: req, code_symbol: sym, code_bits: bits, code_len: len,
                 stream_bit: sbit};
    row.reps = reps;
    row.known = known;
    row.res = '{kind: kind, symbol: rsym, sym_count: sc, bit_count: bc};
    return row;
  endfunction

  // Offers one item until it transfers, then sometimes leaves a gap.
  task automatic drive(input code_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= it.req_type;
    in_ch.code_symbol <= it.code_symbol;
    in_ch.code_bits <= it.code_bits;
    in_ch.code_len <= it.code_len;
    in_ch.stream_bit <= it.stream_bit;
    do @(posedge clk); while (!in_ch.ready);
    if (!(it.req_type == REQ_UNUSED ||
          (it.req_type == pctd_pkg::REQ_LOAD &&
           (it.code_len == 4'd0 || it.code_len > MAX_LEN))))
      work_items++;
    if (!src_steady && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic load_entry(input int unsigned code, input int unsigned len,
                            input logic [7:0] sym);
    code_item_t it;
    it = rand_item(pctd_pkg::REQ_LOAD);
    it.code_symbol = sym;
    it.code_len = 4'(len);
    // Bits above the code length are random and must be ignored.
    it.code_bits = 12'(($urandom << len) | code);
    drive(it);
  endtask

  task automatic send_bits(input int unsigned code, input int unsigned len);
    code_item_t  it;
    int unsigned b;
    for (b = len; b > 0; b--) begin
      it = rand_item(pctd_pkg::REQ_BIT);
      it.stream_bit = 1'((code >> (b - 1)) & 1);
      drive(it);
    end
  endtask

  // Items the block takes and drops: loads with a bad length or the unused code.
  task automatic send_noise();
    code_item_t  it;
    int unsigned len;
    if ($urandom_range(0, 1) == 0) begin
      it = rand_item(pctd_pkg::REQ_LOAD);
      len = $urandom_range(0, 3);
      it.code_len = (len == 0) ? 4'd0 : 4'(len + 12);
    end else begin
      it = rand_item(REQ_UNUSED);
    end
    drive(it);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  initial begin : stimulus
    directed_row_t  rows [DIRECTED_ROWS];
    pinned_result_t pin;
    int unsigned    r;
    int unsigned    k;
    int unsigned    s;
    int unsigned    w;
    int unsigned    session;
    int unsigned    splits;
    int unsigned    depth_cap;
    int unsigned    pick;
    int unsigned    n_words;
    int unsigned    lead;
    int unsigned    order[$];
    bit             deep;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= pctd_pkg::REQ_LOAD;
    in_ch.code_symbol <= 8'd0;
    in_ch.code_bits <= 12'd0;
    in_ch.code_len <= 4'd0;
    in_ch.stream_bit <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    rows[0]  = mk_row(pctd_pkg::REQ_END, 8'h00, 12'h000, 4'd0, 1'b0, 1,
                      1'b1, pctd_pkg::KIND_END, 8'd0, 0, 0);
    rows[1]  = mk_row(pctd_pkg::REQ_LOAD, 8'hAA, 12'hFFF, 4'd0, 1'b1, 1,
                      1'b0, '0, '0, '0, '0);
    rows[2]  = mk_row(pctd_pkg::REQ_LOAD, 8'hAA, 12'hFFF, 4'd13, 1'b0, 1,
                      1'b0, '0, '0, '0, '0);
    rows[3]  = mk_row(pctd_pkg::REQ_LOAD, 8'h55, 12'h000, 4'd15, 1'b1, 1,
                      1'b0, '0, '0, '0, '0);
    rows[4]  = mk_row(REQ_UNUSED, 8'hFF, 12'hFFF, 4'd15, 1'b1, 1,
                      1'b0, '0, '0, '0, '0);
    // Twelve ones walk the empty tree to its deepest level; one more bit overruns.
    rows[5]  = mk_row(pctd_pkg::REQ_BIT, 8'h00, 12'h000, 4'd0, 1'b1, 12,
                      1'b0, '0, '0, '0, '0);
    rows[6]  = mk_row(pctd_pkg::REQ_BIT, 8'h00, 12'h000, 4'd0, 1'b0, 1,
                      1'b1, pctd_pkg::KIND_OVERRUN, 8'd0, 0, 13);
    rows[7]  = mk_row(pctd_pkg::REQ_LOAD, 8'hFF, 12'hFFF, 4'd12, 1'b0, 1,
                      1'b0, '0, '0, '0, '0);
    rows[8]  = mk_row(pctd_pkg::REQ_LOAD, 8'h01, 12'h000, 4'd1, 1'b1, 1,
                      1'b0, '0, '0, '0, '0);
    rows[9]  = mk_row(pctd_pkg::REQ_BIT, 8'h00, 12'h000, 4'd0, 1'b0, 1,
                      1'b1, pctd_pkg::KIND_SYMBOL, 8'd1, 1, 14);
    // A zero symbol empties the node again; the high code bits are ignored.
    rows[10] = mk_row(pctd_pkg::REQ_LOAD, 8'h00, 12'hFFE, 4'd1, 1'b1, 1,
                      1'b0, '0, '0, '0, '0);
    rows[11] = mk_row(pctd_pkg::REQ_BIT, 8'hFF, 12'hFFF, 4'd15, 1'b0, 1,
                      1'b0, '0, '0, '0, '0);
    rows[12] = mk_row(pctd_pkg::REQ_END, 8'h00, 12'h000, 4'd0, 1'b0, 1,
                      1'b1, pctd_pkg::KIND_END, 8'd0, 1, 15);

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      for (r = 0; r < rows[k].reps; r++) begin
        pin.known = rows[k].known;
        pin.res = rows[k].res;
        result_pins.push_back(pin);
        drive(rows[k].item);
      end
    end

    session = 0;
    while (work_items < ITEM_TARGET) begin
      src_steady = (session == 3);
      sink_steady = (session == 3);

      // Usually empty the previous table first; sometimes its symbols stay behind.
      if ($urandom_range(0, 7) != 0)
        while (old_code.size() != 0)
          load_entry(old_code.pop_front(), old_len.pop_front(), 8'd0);
      old_code.delete();
      old_len.delete();

      // Grow a prefix code by splitting leaves; a deep table has a chain to full length.
      leaf_code.delete();
      leaf_len.delete();
      leaf_code.push_back(0);
      leaf_len.push_back(1);
      leaf_code.push_back(1);
      leaf_len.push_back(1);
      deep = (session == 0) || ($urandom_range(0, 5) == 0);
      depth_cap = deep ? MAX_LEN : $urandom_range(2, 6);
      splits = deep ? MAX_LEN - 1 + $urandom_range(0, 3) : $urandom_range(0, 7);
      for (s = 0; s < splits; s++) begin
        pick = (deep && s < MAX_LEN - 1) ? leaf_code.size() - 1
                                         : $urandom_range(0, leaf_code.size() - 1);
        if (leaf_len[pick] < depth_cap) begin
          leaf_code.push_back((leaf_code[pick] << 1) | 1);
          leaf_len.push_back(leaf_len[pick] + 1);
          leaf_code[pick] = leaf_code[pick] << 1;
          leaf_len[pick] = leaf_len[pick] + 1;
        end
      end

      // Load in random order; a few leaves stay empty so walks can run on to an overrun.
      order.delete();
      live.delete();
      for (k = 0; k < leaf_code.size(); k++) order.push_back(k);
      while (order.size() != 0) begin
        k = $urandom_range(0, order.size() - 1);
        pick = order[k];
        order.delete(k);
        if ($urandom_range(0, 7) != 0) begin
          live.push_back(pick);
          load_entry(leaf_code[pick], leaf_len[pick], 8'($urandom_range(1, 255)));
          old_code.push_back(leaf_code[pick]);
          old_len.push_back(leaf_len[pick]);
        end
        if ($urandom_range(0, 6) == 0) send_noise();
      end

      if (session == 1) wait_all_results();
      if (session == 2) begin
        // Results back up behind the stalled output until the input stalls too.
        hold_requests++;
        repeat (8) drive(rand_item(pctd_pkg::REQ_END));
      end

      n_words = $urandom_range(5, 25);
      for (w = 0; w < n_words; w++) begin
        lead = $urandom_range(0, 99);
        if (live.size() != 0 && lead < 80) begin
          pick = live[$urandom_range(0, live.size() - 1)];
          send_bits(leaf_code[pick], leaf_len[pick]);
        end else if (lead < 90) begin
          send_bits($urandom, 1);
        end else if (lead < 96) begin
          send_bits($urandom, $urandom_range(2, 14));
        end else if (live.size() != 0) begin
          // Rewriting a symbol mid-stream must leave the walk where it is.
          pick = live[$urandom_range(0, live.size() - 1)];
          load_entry(leaf_code[pick], leaf_len[pick], 8'($urandom_range(1, 255)));
        end else begin
          send_noise();
        end
      end
      if ($urandom_range(0, 3) != 0) drive(rand_item(pctd_pkg::REQ_END));
      session++;
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d working items over %0d code tables with random stalls on both sides.",
             work_items, session);
    $display("Checked %0d decoded symbols, %0d stream summaries and %0d overruns.",
             seen_symbols, seen_ends, seen_overruns);
    if (mismatch_count == 0) begin
      $display("PASS prefix_code_tree_decoder_unit");
    end else begin
      $display("FAIL prefix_code_tree_decoder_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("FAIL prefix_code_tree_decoder_unit");
    $finish;
  end

endmodule
